[sv/zero_run_delta_word_decoder_assert.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ZERO_RUN_DELTA_WORD_DECODER_ASSERT_SVH
`define ZERO_RUN_DELTA_WORD_DECODER_ASSERT_SVH

// Plain property, clocked on aclk, off during reset.
`define ZRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication.
`define ZRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ZRD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/zrd_pkg.sv]
// Types, codes and constants of the zero-run delta word decoder.
package zrd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 16;
    localparam int BITS_W   = 14;
    localparam int LZ_W     = 3;
    localparam int MAX_RUN  = 6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_LONG_RUN   = 2'd1;
    localparam logic [1:0] ST_BAD_HEADER = 2'd2;

    localparam logic [3:0]  HDR_LITERAL = 4'h0;
    localparam logic [1:0]  HDR_DELTA   = 2'h2;
    localparam logic [11:0] LIT_MASK    = 12'hfff;

    // header classification of one accepted word
    typedef struct packed {
        logic                load;
        logic                single;
        logic [1:0]          status;
        logic [SAMPLE_W-1:0] sample;
        logic [BITS_W-1:0]   bits;
    } hdr_t;

    // one delta decode step
    typedef struct packed {
        logic [BITS_W-1:0]   bits_next;
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } step_t;

endpackage

[sv/zrd_hdr.sv]
// Header classification and long-run precheck of an input word.
module zrd_hdr (
    input  logic [zrd_pkg::SAMPLE_W-1:0] prev_sample,
    input  logic [zrd_pkg::WORD_W-1:0]   code_word,
    output zrd_pkg::hdr_t                hdr
);

    logic long_run;

    // a 1 bit with seven zeros right above it closes a run that is too long
    always_comb begin
        long_run = 1'b0;
        for (int i = 0; i <= zrd_pkg::MAX_RUN; i++) begin
            if (code_word[i] && (code_word[i+1 +: zrd_pkg::MAX_RUN+1] == '0)) begin
                long_run = 1'b1;
            end
        end
    end

    always_comb begin
        hdr.load   = 1'b1;
        hdr.single = 1'b1;
        hdr.status = zrd_pkg::ST_OK;
        hdr.sample = '0;
        hdr.bits   = code_word[zrd_pkg::BITS_W-1:0];
        priority if (code_word[15:12] == zrd_pkg::HDR_LITERAL) begin
            hdr.sample = {4'd0, code_word[11:0] & zrd_pkg::LIT_MASK};
        end else if (code_word[15:14] != zrd_pkg::HDR_DELTA) begin
            hdr.status = zrd_pkg::ST_BAD_HEADER;
        end else if (long_run) begin
            hdr.status = zrd_pkg::ST_LONG_RUN;
        end else if (code_word[zrd_pkg::BITS_W-1:0] == '0) begin
            hdr.load = 1'b0;  // no 1 bits: word gives nothing
        end else begin
            hdr.single = 1'b0;
            hdr.sample = prev_sample;
        end
    end

endmodule

[sv/zrd_step.sv]
// One delta step: find the next 1 bit, apply its delta, shift it out.
module zrd_step (
    input  logic [zrd_pkg::BITS_W-1:0]   bits,
    input  logic [zrd_pkg::SAMPLE_W-1:0] run,
    output zrd_pkg::step_t               stp
);

    logic [zrd_pkg::LZ_W-1:0]     lz;
    logic [zrd_pkg::LZ_W-1:0]     shamt;
    logic [1:0]                   mag;
    logic [zrd_pkg::SAMPLE_W-1:0] delta;

    // run length is known to be at most six here
    always_comb begin
        lz = '0;
        for (int i = zrd_pkg::MAX_RUN; i >= 0; i--) begin
            if (bits[zrd_pkg::BITS_W-1-i]) begin
                lz = zrd_pkg::LZ_W'(i);
            end
        end
    end

    assign shamt = lz + zrd_pkg::LZ_W'(1);
    assign mag   = shamt[2:1];
    assign delta = {{(zrd_pkg::SAMPLE_W-2){1'b0}}, mag};

    assign stp.bits_next = bits << shamt;
    assign stp.sample    = lz[0] ? (run - delta) : (run + delta);
    assign stp.last      = (stp.bits_next == '0);

endmodule

[sv/zero_run_delta_word_decoder.sv]
// Top level of the zero-run delta word decoder.
// Latency: a word's first result is registered in the work stage, then in the output register, before it is on m_*.
// Throughput: one result beat per cycle while m_ready is high; a word holds the work stage
//   until the single step unit has stepped out its last result (1..14 results).
// Words with no 1 bits in a delta body are accepted and dropped.
// Reset: synchronous, active low; clears work and output valids only.
module zero_run_delta_word_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_prev_sample,
    input  logic [15:0] s_code_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_sample,
    output logic [1:0]  m_status,
    output logic        m_last
);

`include "zero_run_delta_word_decoder_assert.svh"

    zrd_pkg::hdr_t  hdr;
    zrd_pkg::step_t stp;

    // work stage: word being expanded
    logic                         work_valid_reg;
    logic                         work_single_reg;
    logic [1:0]                   work_status_reg;
    logic [zrd_pkg::SAMPLE_W-1:0] work_run_reg;
    logic [zrd_pkg::BITS_W-1:0]   work_bits_reg;

    // output stage
    logic                         m_valid_reg;
    logic [zrd_pkg::SAMPLE_W-1:0] m_sample_reg;
    logic [1:0]                   m_status_reg;
    logic                         m_last_reg;

    logic step_en;
    logic work_done;
    logic accept;

    zrd_hdr u_hdr (
        .prev_sample (s_prev_sample),
        .code_word   (s_code_word),
        .hdr         (hdr)
    );

    zrd_step u_step (
        .bits (work_bits_reg),
        .run  (work_run_reg),
        .stp  (stp)
    );

    // a step fires whenever the output slot is free or draining
    assign step_en   = work_valid_reg && (!m_valid_reg || m_ready);
    assign work_done = step_en && (work_single_reg || stp.last);
    assign s_ready   = !work_valid_reg || work_done;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else if (accept) begin
            work_valid_reg <= hdr.load;
        end else if (work_done) begin
            work_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            work_single_reg <= hdr.single;
            work_status_reg <= hdr.status;
            work_run_reg    <= hdr.sample;
            work_bits_reg   <= hdr.bits;
        end else if (step_en && !work_single_reg) begin
            work_run_reg  <= stp.sample;
            work_bits_reg <= stp.bits_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_sample_reg <= work_single_reg ? work_run_reg : stp.sample;
            m_status_reg <= work_single_reg ? work_status_reg : zrd_pkg::ST_OK;
            m_last_reg   <= work_single_reg | stp.last;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;
    assign m_status = m_status_reg;
    assign m_last   = m_last_reg;

    `ZRD_ASSERT_IMP(a_err_beat, m_valid && (m_status != zrd_pkg::ST_OK), m_last && (m_sample == '0), "error beat must be last with zero sample")
    `ZRD_ASSERT_IMP(a_delta_bits, work_valid_reg && !work_single_reg, work_bits_reg != '0, "delta work stage holds no 1 bit")
    `ZRD_ASSERT_NXT(a_step_out, step_en, m_valid, "step did not fill output register")
    `ZRD_ASSERT(a_status_code, !m_valid || (m_status != 2'd3), "undefined status code")

endmodule
